// File: design/srab_pkg.sv
// shared types, constants and state codes for the spectrum bar averager
// no dependencies; the top level imports this package
package srab_pkg;

  // bin range that is averaged
  localparam int unsigned WINDOW_MAX  = 64;
  localparam int unsigned RANGE_FIRST = 5;
  localparam int unsigned RANGE_BINS  = 512;
  localparam int unsigned RANGE_LAST  = RANGE_FIRST + RANGE_BINS - 1;
  localparam int unsigned BARS_LOG2_MAX = 6;

  // memory geometry
  localparam int unsigned HIST_DEPTH = WINDOW_MAX * 2 * RANGE_BINS;
  localparam int unsigned SUM_DEPTH  = 2 * RANGE_BINS;
  localparam int unsigned BAR_DEPTH  = 64;

  // field widths
  localparam int unsigned SUM_W  = 14;
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned LG_W   = 21;
  localparam int unsigned PROD_W = 33;

  // register reset values
  localparam logic [6:0]  WINDOW_LEN_RST  = 7'd8;
  localparam logic [2:0]  BAR_LOG2_RST    = 3'd5;
  localparam logic [11:0] PLOT_HEIGHT_RST = 12'd1024;

  // log offset
  localparam logic [24:0] LOG_OFFSET = 25'd100;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WINDOW_LEN     = 2'd0,
    CFG_BAR_COUNT_LOG2 = 2'd1,
    CFG_PLOT_HEIGHT    = 2'd2,
    CFG_NONE           = 2'd3
  } srab_cfg_t;

  // input word
  typedef struct packed {
    logic [9:0] bin_index;
    logic [7:0] left_sample;
    logic [7:0] right_sample;
    logic       last_bin;
  } srab_in_t;

  // output word
  typedef struct packed {
    logic [5:0]  bar_index;
    logic [11:0] bar_level;
    logic        last_bar;
  } srab_out_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIN_RD,
    ST_BIN_WR,
    ST_FRAME,
    ST_SUM_RD,
    ST_SUM_LD,
    ST_SUM_WAIT,
    ST_BASE_GO,
    ST_BASE_WAIT,
    ST_DEN_GO,
    ST_DEN_WAIT,
    ST_BAR_RD,
    ST_BAR_GO,
    ST_BAR_LOG,
    ST_BAR_MUL,
    ST_BAR_DIV,
    ST_BAR_WAIT,
    ST_BAR_EMIT
  } srab_state_t;

endpackage

// File: design/srab_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module srab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/spectrum_rolling_average_bars_top.sv
// top level of the spectrum bar averager: sequencer, divider, log unit
// depends on srab_pkg and srab_ram
//
// Takes one stereo spectrum bin per input word and keeps a moving-window
// sum per bin and channel for bins 5..516 in a sum ram, with the raw
// samples in a history ram. An in-range bin is accepted, then read and
// written back for each channel; an out-of-range bin is only accepted.
// A word with last_bin set starts the frame pass: all 1024 sums are read
// and divided by the frame count in a radix-2 divider, then each bar
// gets a log2 from a squaring unit, a multiply and, unless the level is
// zero or full, a 33-step divide, then one output word, and the block
// waits until that word is taken. After reset and after every window_len
// write, a clearing pass zeroes all 1024 words of the sum ram; no input
// word is taken during it.
module spectrum_rolling_average_bars_top
  import srab_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  srab_in_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output srab_out_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_data
);

  srab_state_t state, state_next;

  // configuration registers
  logic [6:0]  window_len;
  logic [2:0]  bar_count_log2;
  logic [11:0] plot_height;

  // window state
  logic [5:0] oldest;
  logic [6:0] held;
  logic [9:0] clr_cnt;

  // latched input word and channel select
  srab_in_t item;
  logic     ch;

  // frame pass
  logic [9:0]       kk;
  logic [ACC_W-1:0] acc_l, acc_r;
  logic [LG_W-1:0]  base, den, num;
  logic [5:0]       bidx;
  logic             bar_zero;
  logic [PROD_W-1:0] prod;

  // divider
  logic              dv_busy;
  logic [5:0]        dv_cnt;
  logic [PROD_W-1:0] dv_dvd;
  logic [LG_W-1:0]   dv_d, dv_rem;
  logic [SUM_W-1:0]  dv_q;
  logic              dv_start;
  logic [PROD_W-1:0] dv_dvd_in;
  logic [5:0]        dv_cnt_in;
  logic [LG_W-1:0]   dv_d_in;
  logic [LG_W:0]     dv_trial;

  // log unit
  logic        lg_busy, lg_norm;
  logic [30:0] lg_m;
  logic [4:0]  lg_e;
  logic [15:0] lg_r;
  logic [3:0]  lg_cnt;
  logic        lg_start;
  logic [24:0] lg_v_in;
  logic [61:0] lg_sq;
  logic [31:0] lg_sq_hi;
  logic [LG_W-1:0] lg_res;

  // ram ports
  logic                 sum_we, hist_we, bar_we;
  logic [9:0]           sum_waddr, sum_raddr;
  logic [SUM_W-1:0]     sum_wdata, sum_rdata;
  logic [15:0]          hist_waddr, hist_raddr;
  logic [7:0]           hist_rdata, hist_wdata;
  logic [5:0]           bar_waddr, bar_raddr;
  logic [ACC_W-1:0]     bar_wdata, bar_rdata;

  // output load
  logic        load_out;
  logic [11:0] out_lvl;

  // derived configuration
  logic [6:0]  w_eff;
  logic [2:0]  lg_eff, sh;
  logic [3:0]  ds;
  logic [5:0]  half, bar_last;
  logic [9:0]  div_bins;
  logic [8:0]  bin_mask;
  logic [24:0] full_v;

  // per-word decode
  logic       in_range;
  logic [8:0] k_in, k_sw;
  logic       ch_sw, boundary;
  logic [5:0] slot_new;
  logic [7:0] sample;
  logic [7:0] sub_val;
  logic       cfg_win;

  assign cfg_ready = 1'b1;
  assign cfg_win   = cfg_valid && (cfg_index == CFG_WINDOW_LEN);

  // effective window length and bar geometry
  always_comb begin
    if (window_len == 7'd0) begin
      w_eff = 7'd1;
    end else if (window_len > 7'(WINDOW_MAX)) begin
      w_eff = 7'(WINDOW_MAX);
    end else begin
      w_eff = window_len;
    end
    if (bar_count_log2 == 3'd0) begin
      lg_eff = 3'd1;
    end else if (bar_count_log2 > 3'(BARS_LOG2_MAX)) begin
      lg_eff = 3'(BARS_LOG2_MAX);
    end else begin
      lg_eff = bar_count_log2;
    end
    sh       = lg_eff - 3'd1;
    ds       = 4'd9 - {1'b0, sh};
    half     = 6'd1 << sh;
    bar_last = 6'((7'd1 << lg_eff) - 7'd1);
    div_bins = 10'(RANGE_BINS) >> sh;
    full_v   = 25'({div_bins, 8'd0} - {8'd0, div_bins}) + LOG_OFFSET;
    bin_mask = ~(9'h1ff << ds);
  end

  // input bin decode
  assign in_range = (item.bin_index >= 10'(RANGE_FIRST)) &&
                    (item.bin_index <= 10'(RANGE_LAST));
  assign k_in     = 9'(item.bin_index - 10'(RANGE_FIRST));
  assign slot_new = oldest + held[5:0];
  assign sample   = ch ? item.right_sample : item.left_sample;
  assign sub_val  = (held >= w_eff) ? hist_rdata : 8'd0;

  // frame pass decode
  assign ch_sw    = kk[0];
  assign k_sw     = kk[9:1];
  assign boundary = (k_sw & bin_mask) == bin_mask;

  // divider and log datapath
  assign dv_trial = {dv_rem, dv_dvd[PROD_W-1]};
  assign lg_sq    = 62'(lg_m) * 62'(lg_m);
  assign lg_sq_hi = lg_sq[61:30];
  assign lg_res   = {lg_e, lg_r};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == 10'(SUM_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if ((in_word.bin_index >= 10'(RANGE_FIRST)) &&
              (in_word.bin_index <= 10'(RANGE_LAST))) begin
            state_next = ST_BIN_RD;
          end else if (in_word.last_bin) begin
            state_next = ST_FRAME;
          end
        end
      end
      ST_BIN_RD: state_next = ST_BIN_WR;
      ST_BIN_WR: begin
        if (!ch) state_next = ST_BIN_RD;
        else if (item.last_bin) state_next = ST_FRAME;
        else state_next = ST_IDLE;
      end
      ST_FRAME:  state_next = ST_SUM_RD;
      ST_SUM_RD: state_next = ST_SUM_LD;
      ST_SUM_LD: state_next = ST_SUM_WAIT;
      ST_SUM_WAIT: begin
        if (!dv_busy) begin
          state_next = (kk == 10'(SUM_DEPTH - 1)) ? ST_BASE_GO : ST_SUM_RD;
        end
      end
      ST_BASE_GO: state_next = ST_BASE_WAIT;
      ST_BASE_WAIT: begin
        if (!lg_busy) state_next = ST_DEN_GO;
      end
      ST_DEN_GO: state_next = ST_DEN_WAIT;
      ST_DEN_WAIT: begin
        if (!lg_busy) state_next = ST_BAR_RD;
      end
      ST_BAR_RD:  state_next = ST_BAR_GO;
      ST_BAR_GO:  state_next = ST_BAR_LOG;
      ST_BAR_LOG: begin
        if (!lg_busy) state_next = ST_BAR_MUL;
      end
      ST_BAR_MUL: state_next = ST_BAR_DIV;
      ST_BAR_DIV: begin
        if (bar_zero || den == '0 || num >= den) state_next = ST_BAR_EMIT;
        else state_next = ST_BAR_WAIT;
      end
      ST_BAR_WAIT: begin
        if (!dv_busy) state_next = ST_BAR_EMIT;
      end
      ST_BAR_EMIT: begin
        if (out_valid && out_ready) begin
          state_next = (bidx == bar_last) ? ST_IDLE : ST_BAR_RD;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
    // a window length write restarts the clearing pass
    if (cfg_win) state_next = ST_CLEAR;
  end

  // ram controls and unit starts
  always_comb begin
    in_ready   = 1'b0;
    sum_we     = 1'b0;
    sum_waddr  = {ch, k_in};
    sum_wdata  = sum_rdata - SUM_W'(sub_val) + SUM_W'(sample);
    sum_raddr  = {ch, k_in};
    hist_we    = 1'b0;
    hist_waddr = {slot_new, ch, k_in};
    hist_wdata = sample;
    hist_raddr = {oldest, ch, k_in};
    bar_we     = 1'b0;
    bar_waddr  = ch_sw ? 6'(half + 6'(k_sw >> ds)) : 6'((~k_sw) >> ds);
    bar_wdata  = (ch_sw ? acc_r : acc_l) + ACC_W'(dv_q);
    bar_raddr  = bidx;
    dv_start   = 1'b0;
    dv_dvd_in  = {sum_rdata, 19'd0};
    dv_cnt_in  = 6'(SUM_W);
    dv_d_in    = LG_W'(held);
    lg_start   = 1'b0;
    lg_v_in    = LOG_OFFSET;
    load_out   = 1'b0;
    out_lvl    = 12'd0;
    unique case (state)
      ST_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_cnt;
        sum_wdata = '0;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_BIN_WR: begin
        sum_we  = 1'b1;
        hist_we = 1'b1;
      end
      ST_SUM_RD: sum_raddr = {ch_sw, k_sw};
      ST_SUM_LD: dv_start = 1'b1;
      ST_SUM_WAIT: begin
        if (!dv_busy && boundary) bar_we = 1'b1;
      end
      ST_BASE_GO: lg_start = 1'b1;
      ST_DEN_GO: begin
        lg_start = 1'b1;
        lg_v_in  = full_v;
      end
      ST_BAR_GO: begin
        lg_start = 1'b1;
        lg_v_in  = 25'(bar_rdata) + LOG_OFFSET;
      end
      ST_BAR_DIV: begin
        if (bar_zero || den == '0) begin
          load_out = 1'b1;
        end else if (num >= den) begin
          load_out = 1'b1;
          out_lvl  = plot_height;
        end else begin
          dv_start  = 1'b1;
          dv_dvd_in = prod;
          dv_cnt_in = 6'(PROD_W);
          dv_d_in   = den;
        end
      end
      ST_BAR_WAIT: begin
        if (!dv_busy) begin
          load_out = 1'b1;
          out_lvl  = dv_q[11:0];
        end
      end
      default: ;
    endcase
  end

  // sequencer registers and frame pass datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      window_len     <= WINDOW_LEN_RST;
      bar_count_log2 <= BAR_LOG2_RST;
      plot_height    <= PLOT_HEIGHT_RST;
      oldest         <= '0;
      held           <= '0;
      clr_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WINDOW_LEN:     window_len     <= cfg_data[6:0];
          CFG_BAR_COUNT_LOG2: bar_count_log2 <= cfg_data[2:0];
          CFG_PLOT_HEIGHT:    plot_height    <= cfg_data;
          default: ;
        endcase
      end
      // clearing pass counter
      if (cfg_win) begin
        clr_cnt <= '0;
        oldest  <= '0;
        held    <= '0;
      end else begin
        if (state == ST_CLEAR) clr_cnt <= clr_cnt + 10'd1;
        // window advance at frame end
        if (state == ST_FRAME) begin
          if (held < w_eff) held <= held + 7'd1;
          else oldest <= oldest + 6'd1;
        end
      end
      // output word register
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_word;
      ch   <= 1'b0;
    end
    if (state == ST_BIN_WR) ch <= 1'b1;
    if (state == ST_FRAME) begin
      kk    <= '0;
      acc_l <= '0;
      acc_r <= '0;
    end
    // accumulate averages into the running bar sums
    if (state == ST_SUM_WAIT && !dv_busy) begin
      kk <= kk + 10'd1;
      if (ch_sw) acc_r <= boundary ? '0 : acc_r + ACC_W'(dv_q);
      else acc_l <= boundary ? '0 : acc_l + ACC_W'(dv_q);
    end
    if (state == ST_BASE_WAIT && !lg_busy) base <= lg_res;
    if (state == ST_DEN_WAIT && !lg_busy) begin
      den  <= lg_res - base;
      bidx <= '0;
    end
    if (state == ST_BAR_GO) bar_zero <= (bar_rdata == '0);
    if (state == ST_BAR_LOG && !lg_busy) num <= lg_res - base;
    if (state == ST_BAR_MUL) prod <= PROD_W'(plot_height) * PROD_W'(num);
    if (state == ST_BAR_EMIT && out_valid && out_ready) bidx <= bidx + 6'd1;
    if (load_out) begin
      out_word.bar_index <= bidx;
      out_word.bar_level <= out_lvl;
      out_word.last_bar  <= (bidx == bar_last);
    end
  end

  // radix-2 restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (dv_start) begin
      dv_busy <= 1'b1;
    end else if (dv_busy && dv_cnt == 6'd1) begin
      dv_busy <= 1'b0;
    end
    if (dv_start) begin
      dv_dvd <= dv_dvd_in;
      dv_cnt <= dv_cnt_in;
      dv_d   <= dv_d_in;
      dv_rem <= '0;
      dv_q   <= '0;
    end else if (dv_busy) begin
      dv_dvd <= {dv_dvd[PROD_W-2:0], 1'b0};
      dv_cnt <= dv_cnt - 6'd1;
      if (dv_trial >= {1'b0, dv_d}) begin
        dv_rem <= LG_W'(dv_trial - {1'b0, dv_d});
        dv_q   <= {dv_q[SUM_W-2:0], 1'b1};
      end else begin
        dv_rem <= dv_trial[LG_W-1:0];
        dv_q   <= {dv_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  // log2 in q16: normalize one bit a cycle, then 16 squarings
  always_ff @(posedge clk) begin
    if (rst) begin
      lg_busy <= 1'b0;
    end else if (lg_start) begin
      lg_busy <= 1'b1;
    end else if (lg_busy && !lg_norm && lg_cnt == 4'd15) begin
      lg_busy <= 1'b0;
    end
    if (lg_start) begin
      lg_m    <= 31'(lg_v_in);
      lg_e    <= 5'd30;
      lg_r    <= '0;
      lg_norm <= 1'b1;
      lg_cnt  <= '0;
    end else if (lg_busy) begin
      if (lg_norm) begin
        if (!lg_m[30]) begin
          lg_m <= {lg_m[29:0], 1'b0};
          lg_e <= lg_e - 5'd1;
        end else begin
          lg_norm <= 1'b0;
        end
      end else begin
        lg_cnt <= lg_cnt + 4'd1;
        if (lg_sq_hi[31]) begin
          lg_r <= {lg_r[14:0], 1'b1};
          lg_m <= lg_sq_hi[31:1];
        end else begin
          lg_r <= {lg_r[14:0], 1'b0};
          lg_m <= lg_sq_hi[30:0];
        end
      end
    end
  end

  // window sums per channel and bin
  srab_ram #(.WIDTH(SUM_W), .DEPTH(SUM_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // sample history by slot, channel and bin
  srab_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // bar sums of the current frame
  srab_ram #(.WIDTH(ACC_W), .DEPTH(BAR_DEPTH)) u_bar_ram (
    .clk   (clk),
    .we    (bar_we),
    .waddr (bar_waddr),
    .wdata (bar_wdata),
    .raddr (bar_raddr),
    .rdata (bar_rdata)
  );

  // input is never taken while a bar word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a bar word is pending");

  // divider and log unit are never busy together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(dv_busy && lg_busy))
    else $error("divider and log unit overlap");

  // last bar flag sits on the highest bar index
  a_last_bar: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.last_bar) |-> (out_word.bar_index == bar_last))
    else $error("last bar flag on wrong bar");

endmodule
